// ===== src/i2c_target_register_file_assert.svh =====
// Assertion macros for the I2C target register file.
// Included by the modules that check their own sequencing; needs clk and rst in scope.
`ifndef I2C_TARGET_REGISTER_FILE_ASSERT_SVH
`define I2C_TARGET_REGISTER_FILE_ASSERT_SVH
`ifndef SYNTHESIS
`define RF_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define RF_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RF_ASSERT_IMP(lbl, pre, post, msg)
`define RF_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/i2c_rf_pkg.sv =====
// Shared types and constants of the I2C target register file.
// No dependencies; used by the bank, the sequencer and the top level.
package i2c_rf_pkg;

  localparam int BANK_AW = 5;
  localparam int CNT_W = BANK_AW + 1;
  localparam int CFG_AW = 4;

  localparam int DEF_REGISTER_COUNT = 32;
  localparam int DEF_CHECKSUM_INDEX = 31;
  localparam int DEF_CONTROL_INDEX = 0;
  localparam int DEF_SYNC_INDEX = 8;
  localparam int DEF_STATUS_INDEX = 7;
  localparam int DEF_LOCAL_LIMIT = 30;

  localparam int MODE_INDEX = 1;
  localparam int RATE_INDEX = 2;
  localparam int ADC_SEL_INDEX = 3;
  localparam int DIG_SEL_INDEX = 4;
  localparam int NODE_INDEX = 5;
  localparam int CLUSTER_INDEX = 6;

  localparam logic [7:0] RUN_BIT = 8'h01;
  localparam logic [7:0] STOP_BIT = 8'h02;
  localparam logic [7:0] RESET_BIT = 8'h04;
  localparam logic [7:0] ADC_SEL_DEFAULT = 8'h0F;
  localparam logic [7:0] DIG_SEL_DEFAULT = 8'hFF;

  typedef enum logic [2:0] {
    ACT_SET_PTR,
    ACT_BUS_WRITE,
    ACT_BUS_READ,
    ACT_STATUS,
    ACT_CLR_EVENT,
    ACT_TAKE_CHANGED,
    ACT_LOCAL_READ,
    ACT_INIT
  } action_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_START,
    EV_STOP,
    EV_RESET
  } event_t;

  typedef enum logic [1:0] {
    CFG_NODE,
    CFG_CLUSTER,
    CFG_MODE,
    CFG_RATE
  } cfg_index_t;

  typedef struct packed {
    logic               we;
    logic [BANK_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [BANK_AW-1:0] raddr;
  } bank_req_t;

  typedef struct packed {
    logic [7:0] node;
    logic [7:0] cluster;
    logic [7:0] mode;
    logic [7:0] rate;
  } defaults_t;

endpackage

// ===== src/i2c_rf_bank.sv =====
// Register bank storage: one write port and one registered read port.
// Depends on i2c_rf_pkg for the request struct.
module i2c_rf_bank #(
  parameter int REGISTER_COUNT = i2c_rf_pkg::DEF_REGISTER_COUNT
) (
  input  logic                  clk,
  input  i2c_rf_pkg::bank_req_t req,
  output logic [7:0]            rdata
);

  localparam int IW = $clog2(REGISTER_COUNT);

  logic [7:0] mem [REGISTER_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[IW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.raddr[IW-1:0]];
  end

endmodule

// ===== src/i2c_rf_seq.sv =====
// Action sequencer: decodes each command, sweeps the bank for clears, defaults and
// the checksum through one XOR accumulator, and steps the pointer by repeated subtraction.
// Depends on i2c_rf_pkg and the assertion header.
`include "i2c_target_register_file_assert.svh"
module i2c_rf_seq #(
  parameter int REGISTER_COUNT = i2c_rf_pkg::DEF_REGISTER_COUNT,
  parameter int CHECKSUM_INDEX = i2c_rf_pkg::DEF_CHECKSUM_INDEX,
  parameter int CONTROL_INDEX  = i2c_rf_pkg::DEF_CONTROL_INDEX,
  parameter int SYNC_INDEX     = i2c_rf_pkg::DEF_SYNC_INDEX,
  parameter int STATUS_INDEX   = i2c_rf_pkg::DEF_STATUS_INDEX,
  parameter int LOCAL_LIMIT    = i2c_rf_pkg::DEF_LOCAL_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            action,
  input  logic [7:0]            target_addr,
  input  logic [7:0]            data_byte,
  input  logic [7:0]            status_mask,
  input  logic                  status_level,
  input  i2c_rf_pkg::defaults_t defaults,
  output logic                  done,
  output logic [7:0]            read_data,
  output logic [1:0]            pending_event,
  output logic                  changed_flag,
  output logic                  address_error,
  output i2c_rf_pkg::bank_req_t bank_req,
  input  logic [7:0]            bank_rdata
);

  localparam int CW = i2c_rf_pkg::CNT_W;
  localparam int AW = i2c_rf_pkg::BANK_AW;
  localparam bit CHK_LIVE = CHECKSUM_INDEX < REGISTER_COUNT;
  localparam bit STS_LIVE = STATUS_INDEX < REGISTER_COUNT;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIPE,
    S_INIT,
    S_WRITE,
    S_SUM,
    S_STEP,
    S_FETCH,
    S_LREAD,
    S_STATUS
  } state_t;

  state_t                 state;
  i2c_rf_pkg::action_t    act_q;
  i2c_rf_pkg::event_t     event_q;
  logic [7:0]             addr_q;
  logic [7:0]             data_q;
  logic [7:0]             mask_q;
  logic                   level_q;
  logic                   aerr_q;
  logic [CW-1:0]          cnt;
  logic [7:0]             acc;
  logic [8:0]             step_val;
  logic [7:0]             pointer;
  logic                   dirty;

  logic                   addr_live;
  logic                   ptr_live;
  logic                   local_bad;
  logic [7:0]             init_byte;
  logic [7:0]             sum_next;
  logic [7:0]             init_next;
  logic                   sum_last;
  logic                   read_phase;

  assign busy = (state != S_IDLE);
  assign pending_event = event_q;
  assign addr_live = target_addr < 8'(REGISTER_COUNT);
  assign ptr_live = pointer < 8'(REGISTER_COUNT);
  assign local_bad = (target_addr > 8'(LOCAL_LIMIT)) || !addr_live;
  assign sum_last = (state == S_SUM) && (cnt == CW'(REGISTER_COUNT));
  assign read_phase = (state == S_STEP) || (state == S_FETCH) || (state == S_LREAD);

  always_comb begin
    priority if (cnt == CW'(i2c_rf_pkg::CLUSTER_INDEX)) begin
      init_byte = defaults.cluster;
    end else if (cnt == CW'(i2c_rf_pkg::NODE_INDEX)) begin
      init_byte = defaults.node;
    end else if (cnt == CW'(i2c_rf_pkg::DIG_SEL_INDEX)) begin
      init_byte = i2c_rf_pkg::DIG_SEL_DEFAULT;
    end else if (cnt == CW'(i2c_rf_pkg::ADC_SEL_INDEX)) begin
      init_byte = i2c_rf_pkg::ADC_SEL_DEFAULT;
    end else if (cnt == CW'(i2c_rf_pkg::RATE_INDEX)) begin
      init_byte = defaults.rate;
    end else if (cnt == CW'(i2c_rf_pkg::MODE_INDEX)) begin
      init_byte = defaults.mode;
    end else if (cnt == CW'(CONTROL_INDEX)) begin
      init_byte = i2c_rf_pkg::STOP_BIT;
    end else begin
      init_byte = 8'h00;
    end
  end

  // The bank read is registered, so the read data belongs to the sweep address before the current one.
  assign sum_next = ((cnt != '0) && (cnt != CW'(CHECKSUM_INDEX + 1))) ? (acc ^ bank_rdata) : acc;
  assign init_next = (cnt != CW'(CHECKSUM_INDEX)) ? (acc ^ init_byte) : acc;

  always_comb begin
    bank_req.we = 1'b0;
    bank_req.waddr = '0;
    bank_req.wdata = 8'h00;
    bank_req.raddr = pointer[AW-1:0];
    unique case (state)
      S_WIPE: begin
        bank_req.we = 1'b1;
        bank_req.waddr = cnt[AW-1:0];
      end
      S_INIT: begin
        if (cnt < CW'(REGISTER_COUNT)) begin
          bank_req.we = 1'b1;
          bank_req.waddr = cnt[AW-1:0];
          bank_req.wdata = init_byte;
        end else if (CHK_LIVE) begin
          bank_req.we = 1'b1;
          bank_req.waddr = AW'(CHECKSUM_INDEX);
          bank_req.wdata = acc;
        end
      end
      S_WRITE: begin
        bank_req.we = 1'b1;
        bank_req.waddr = addr_q[AW-1:0];
        bank_req.wdata = data_q;
      end
      S_SUM: begin
        bank_req.raddr = cnt[AW-1:0];
        if (cnt == CW'(REGISTER_COUNT)) begin
          bank_req.we = 1'b1;
          bank_req.waddr = AW'(CHECKSUM_INDEX);
          bank_req.wdata = sum_next;
        end
      end
      S_FETCH: begin
        bank_req.raddr = addr_q[AW-1:0];
      end
      S_STATUS: begin
        bank_req.we = 1'b1;
        bank_req.waddr = addr_q[AW-1:0];
        bank_req.wdata = level_q ? (bank_rdata | mask_q) : (bank_rdata & ~mask_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      cnt <= '0;
      pointer <= 8'h00;
      event_q <= i2c_rf_pkg::EV_NONE;
      dirty <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act_q <= i2c_rf_pkg::action_t'(action);
            addr_q <= target_addr;
            data_q <= data_byte;
            mask_q <= status_mask;
            level_q <= status_level;
            cnt <= '0;
            acc <= 8'h00;
            read_data <= 8'h00;
            address_error <= 1'b0;
            changed_flag <= dirty;
            unique case (i2c_rf_pkg::action_t'(action))
              i2c_rf_pkg::ACT_SET_PTR: begin
                pointer <= target_addr;
                address_error <= !addr_live;
                done <= 1'b1;
              end
              i2c_rf_pkg::ACT_BUS_WRITE: begin
                pointer <= target_addr;
                if (!addr_live) begin
                  address_error <= 1'b1;
                  done <= 1'b1;
                end else begin
                  if (target_addr == 8'(SYNC_INDEX)) begin
                    event_q <= (data_byte != 8'h00) ? i2c_rf_pkg::EV_START
                                                    : i2c_rf_pkg::EV_STOP;
                  end else if (target_addr == 8'(CONTROL_INDEX)) begin
                    priority if ((data_byte & i2c_rf_pkg::RUN_BIT) != 8'h00) begin
                      event_q <= i2c_rf_pkg::EV_START;
                    end else if ((data_byte & i2c_rf_pkg::STOP_BIT) != 8'h00) begin
                      event_q <= i2c_rf_pkg::EV_STOP;
                    end else if ((data_byte & i2c_rf_pkg::RESET_BIT) != 8'h00) begin
                      event_q <= i2c_rf_pkg::EV_RESET;
                    end
                  end
                  dirty <= 1'b1;
                  state <= S_WRITE;
                end
              end
              i2c_rf_pkg::ACT_BUS_READ: begin
                step_val <= {1'b0, pointer} + 9'd1;
                aerr_q <= !ptr_live;
                state <= S_STEP;
              end
              i2c_rf_pkg::ACT_STATUS: begin
                if (STS_LIVE) begin
                  addr_q <= 8'(STATUS_INDEX);
                  state <= S_FETCH;
                end else begin
                  done <= 1'b1;
                end
              end
              i2c_rf_pkg::ACT_CLR_EVENT: begin
                event_q <= i2c_rf_pkg::EV_NONE;
                done <= 1'b1;
              end
              i2c_rf_pkg::ACT_TAKE_CHANGED: begin
                dirty <= 1'b0;
                done <= 1'b1;
              end
              i2c_rf_pkg::ACT_LOCAL_READ: begin
                if (local_bad) begin
                  address_error <= 1'b1;
                  done <= 1'b1;
                end else begin
                  state <= S_FETCH;
                end
              end
              i2c_rf_pkg::ACT_INIT: begin
                state <= S_INIT;
              end
            endcase
          end
        end
        S_WIPE: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(REGISTER_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_INIT: begin
          if (cnt < CW'(REGISTER_COUNT)) begin
            acc <= init_next;
            cnt <= cnt + 1'b1;
          end else begin
            changed_flag <= dirty;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_WRITE: begin
          if (CHK_LIVE) begin
            state <= S_SUM;
          end else begin
            changed_flag <= dirty;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          if (cnt == CW'(REGISTER_COUNT)) begin
            changed_flag <= dirty;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            acc <= sum_next;
            cnt <= cnt + 1'b1;
          end
        end
        S_STEP: begin
          if (step_val >= 9'(REGISTER_COUNT)) begin
            step_val <= step_val - 9'(REGISTER_COUNT);
          end else begin
            pointer <= step_val[7:0];
            read_data <= aerr_q ? 8'h00 : bank_rdata;
            address_error <= aerr_q;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_FETCH: begin
          state <= (act_q == i2c_rf_pkg::ACT_STATUS) ? S_STATUS : S_LREAD;
        end
        S_LREAD: begin
          read_data <= bank_rdata;
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_STATUS: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RF_ASSERT_IMP(a_done_idle, done, state == S_IDLE, "result beat while sequencer busy")
  `RF_ASSERT_NXT(a_sum_done, sum_last, done, "checksum sweep ended without a result beat")
  `RF_ASSERT_IMP(a_wipe_quiet, state == S_WIPE, !done, "result beat during reset clear")
  `RF_ASSERT_IMP(a_write_state, bank_req.we, busy && !read_phase, "stray bank write")

endmodule

// ===== src/i2c_target_register_file.sv =====
// Top level of the I2C target register file: configuration registers on the APB-style
// port, the action sequencer and the register bank.
// Depends on i2c_rf_pkg, i2c_rf_seq and i2c_rf_bank.
//
// Usage: a command beat is taken at a rising edge with start high and busy low; it
// carries action, target_addr, data_byte, status_mask and status_level. Each command
// gives exactly one result beat: done is high for one cycle with read_data,
// pending_event, changed_flag and address_error valid. The receiver cannot stall.
// Set pointer, clear event, take changed and any rejected address give done straight
// from idle; a bus read steps the pointer by one, wrapping it into the file by repeated
// subtraction of REGISTER_COUNT, and returns the byte at the old pointer; local read and
// status update go through the registered bank read. A bus write stores the byte and,
// when the checksum register lies in the file, runs the one-entry-per-cycle checksum
// sweep over the bank read port; initialise makes one bank write per cycle. A new command
// may be taken in the done cycle. After reset the bank is cleared with busy high;
// configuration writes are taken at any time and are applied on initialise.
module i2c_target_register_file #(
  parameter int REGISTER_COUNT = i2c_rf_pkg::DEF_REGISTER_COUNT,
  parameter int CHECKSUM_INDEX = i2c_rf_pkg::DEF_CHECKSUM_INDEX,
  parameter int CONTROL_INDEX  = i2c_rf_pkg::DEF_CONTROL_INDEX,
  parameter int SYNC_INDEX     = i2c_rf_pkg::DEF_SYNC_INDEX,
  parameter int STATUS_INDEX   = i2c_rf_pkg::DEF_STATUS_INDEX,
  parameter int LOCAL_LIMIT    = i2c_rf_pkg::DEF_LOCAL_LIMIT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    action,
  input  logic [7:0]                    target_addr,
  input  logic [7:0]                    data_byte,
  input  logic [7:0]                    status_mask,
  input  logic                          status_level,
  output logic                          done,
  output logic [7:0]                    read_data,
  output logic [1:0]                    pending_event,
  output logic                          changed_flag,
  output logic                          address_error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2c_rf_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = i2c_rf_pkg::CFG_AW;

  i2c_rf_pkg::defaults_t  defaults;
  i2c_rf_pkg::bank_req_t  bank_req;
  i2c_rf_pkg::cfg_index_t cfg_sel;
  logic [7:0]             bank_rdata;
  logic                   cfg_write;

  assign pready = 1'b1;
  assign cfg_sel = i2c_rf_pkg::cfg_index_t'(paddr[AW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      defaults <= '0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        i2c_rf_pkg::CFG_NODE:    defaults.node <= pwdata[7:0];
        i2c_rf_pkg::CFG_CLUSTER: defaults.cluster <= pwdata[7:0];
        i2c_rf_pkg::CFG_MODE:    defaults.mode <= pwdata[7:0];
        i2c_rf_pkg::CFG_RATE:    defaults.rate <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      i2c_rf_pkg::CFG_NODE:    prdata = {24'h0, defaults.node};
      i2c_rf_pkg::CFG_CLUSTER: prdata = {24'h0, defaults.cluster};
      i2c_rf_pkg::CFG_MODE:    prdata = {24'h0, defaults.mode};
      i2c_rf_pkg::CFG_RATE:    prdata = {24'h0, defaults.rate};
    endcase
  end

  i2c_rf_seq #(
    .REGISTER_COUNT (REGISTER_COUNT),
    .CHECKSUM_INDEX (CHECKSUM_INDEX),
    .CONTROL_INDEX  (CONTROL_INDEX),
    .SYNC_INDEX     (SYNC_INDEX),
    .STATUS_INDEX   (STATUS_INDEX),
    .LOCAL_LIMIT    (LOCAL_LIMIT)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .target_addr   (target_addr),
    .data_byte     (data_byte),
    .status_mask   (status_mask),
    .status_level  (status_level),
    .defaults      (defaults),
    .done          (done),
    .read_data     (read_data),
    .pending_event (pending_event),
    .changed_flag  (changed_flag),
    .address_error (address_error),
    .bank_req      (bank_req),
    .bank_rdata    (bank_rdata)
  );

  i2c_rf_bank #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_bank (
    .clk   (clk),
    .req   (bank_req),
    .rdata (bank_rdata)
  );

endmodule
